@@ hdl/ngs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next greater element stack: shared package
// Sizes, the result word layout and the controller/datapath signal groups.
// ----------------------------------------------------------------------------
package ngs_pkg;

  // Stack and field sizes.
  localparam int StackDepth   = 32;
  localparam int CountW       = $clog2(StackDepth + 1);
  localparam int IndexW       = $clog2(StackDepth);
  localparam int PositionBits = 20;
  localparam int ValueW       = 32;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_FLUSH
  } ngs_state_e;

  // One result word.
  typedef struct packed {
    logic [PositionBits-1:0]  position;
    logic signed [ValueW-1:0] greater_value;
    logic                     found;
    logic                     overflow;
    logic                     last_of_run;
  } ngs_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pop_emit;
    logic ovf_emit;
    logic flush_emit;
    logic push;
    logic finish;
  } ngs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stage_full;
    logic out_free;
    logic stack_empty;
    logic stack_full;
    logic top_less;
    logic eos;
  } ngs_sts_t;

endpackage

@@ hdl/ngs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next greater element stack: channel interfaces
// Sample channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ngs_in_if import ngs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] sample_value;
  logic                     end_of_sequence;

  modport source (output valid, output sample_value, output end_of_sequence, input ready);
  modport sink   (input valid, input sample_value, input end_of_sequence, output ready);
endinterface

interface ngs_out_if import ngs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PositionBits-1:0]  position;
  logic signed [ValueW-1:0] greater_value;
  logic                     found;
  logic                     overflow;
  logic                     last_of_run;

  modport source (output valid, output position, output greater_value, output found,
                  output overflow, output last_of_run, input ready);
  modport sink   (input valid, input position, input greater_value, input found,
                  input overflow, input last_of_run, output ready);
endinterface

@@ hdl/ngs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next greater element stack: controller
// Sequences the accept, pop, push/overflow and flush steps of each sample.
// ----------------------------------------------------------------------------
module ngs_ctrl import ngs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ngs_sts_t sts_i,
  output ngs_cmd_t cmd_o
);

  ngs_state_e state_q, state_d;
  logic       stage_ok;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A new result may enter the staging register if it is empty or drains now.
  assign stage_ok = !sts_i.stage_full || sts_i.out_free;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        // The staged result of the previous sample is the last of its run.
        in_ready_o   = stage_ok;
        cmd_o.finish = sts_i.stage_full && sts_i.out_free;
        if (in_valid_i && stage_ok) begin
          cmd_o.load = 1'b1;
          state_d    = ST_POP;
        end
      end
      ST_POP: begin
        if (!sts_i.stack_empty && sts_i.top_less) begin
          cmd_o.pop_emit = stage_ok;
        end else if (sts_i.stack_full) begin
          if (stage_ok) begin
            cmd_o.ovf_emit = 1'b1;
            state_d        = sts_i.eos ? ST_FLUSH : ST_IDLE;
          end
        end else begin
          cmd_o.push = 1'b1;
          state_d    = sts_i.eos ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts_i.stack_empty) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.flush_emit = stage_ok;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/ngs_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next greater element stack: datapath
// Stack storage, position counter, current sample, staging and output words.
// ----------------------------------------------------------------------------
module ngs_datapath import ngs_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [ValueW-1:0] sample_value_i,
  input  logic                     end_of_sequence_i,
  input  logic                     out_ready_i,
  input  ngs_cmd_t                 cmd_i,
  output ngs_sts_t                 sts_o,
  output logic                     out_valid_o,
  output ngs_res_t                 out_word_o
);

  logic signed [ValueW-1:0] stack_val_q [StackDepth];
  logic [PositionBits-1:0]  stack_pos_q [StackDepth];
  logic [CountW-1:0]        count_q;
  logic [PositionBits-1:0]  pos_cnt_q;
  logic signed [ValueW-1:0] cur_val_q;
  logic [PositionBits-1:0]  cur_pos_q;
  logic                     cur_eos_q;
  ngs_res_t                 stage_q, stage_d;
  logic                     stage_full_q;
  ngs_res_t                 out_q, out_d;
  logic                     out_valid_q;
  logic [IndexW-1:0]        top_idx;
  logic [IndexW-1:0]        push_idx;
  logic                     emit;
  logic                     out_load;

  assign top_idx  = IndexW'(count_q - CountW'(1));
  assign push_idx = count_q[IndexW-1:0];
  assign emit     = cmd_i.pop_emit || cmd_i.ovf_emit || cmd_i.flush_emit;
  assign out_load = cmd_i.finish || (emit && stage_full_q);

  // Status towards the controller.
  always_comb begin
    sts_o.stage_full  = stage_full_q;
    sts_o.out_free    = !out_valid_q || out_ready_i;
    sts_o.stack_empty = (count_q == '0);
    sts_o.stack_full  = (count_q == CountW'(StackDepth));
    sts_o.top_less    = stack_val_q[top_idx] < cur_val_q;
    sts_o.eos         = cur_eos_q;
  end

  // Current sample and position counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_cnt_q <= '0;
    end else if (cmd_i.load) begin
      pos_cnt_q <= end_of_sequence_i ? '0 : pos_cnt_q + PositionBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_val_q <= sample_value_i;
      cur_pos_q <= pos_cnt_q;
      cur_eos_q <= end_of_sequence_i;
    end
  end

  // Stack depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.pop_emit || cmd_i.flush_emit) begin
      count_q <= count_q - CountW'(1);
    end else if (cmd_i.push) begin
      count_q <= count_q + CountW'(1);
    end
  end

  // Stack storage, written on a push.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      stack_val_q[push_idx] <= cur_val_q;
      stack_pos_q[push_idx] <= cur_pos_q;
    end
  end

  // New result word for the staging register.
  always_comb begin
    stage_d = '0;
    if (cmd_i.pop_emit) begin
      stage_d.position      = stack_pos_q[top_idx];
      stage_d.greater_value = cur_val_q;
      stage_d.found         = 1'b1;
    end else if (cmd_i.ovf_emit) begin
      stage_d.position = cur_pos_q;
      stage_d.overflow = 1'b1;
    end else begin
      stage_d.position = stack_pos_q[top_idx];
    end
  end

  // The staging register holds a result until it is known whether another follows.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_full_q <= 1'b0;
    end else if (emit) begin
      stage_full_q <= 1'b1;
    end else if (cmd_i.finish) begin
      stage_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      stage_q <= stage_d;
    end
  end

  // Output word, marked as the last of its run when the sample is done.
  always_comb begin
    out_d             = stage_q;
    out_d.last_of_run = cmd_i.finish;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ hdl/next_greater_element_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next greater element stack: top level
// Resolves the next greater element of each sample with a monotonic stack.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on sample_i (sample_value, end_of_sequence); result words
//   leave on result_o, each with the resolved position, its next greater
//   value, found, overflow and last_of_run. Both channels move one word per
//   cycle where valid and ready are both high.
//   A sample is accepted, then pops each entry smaller than itself, then is
//   pushed, or reported in an overflow word when the stack is full. A sample
//   that ends a sequence then flushes the remaining entries before the
//   controller returns to idle. Each result word waits in a staging register
//   until the next one is made or the sample is done, so the last word of a
//   sample leaves the staging register once the controller is back in idle.
//   Words come out in pop order, the top of the stack first.
//   Reset empties the stack and restarts the position count at zero.
//   When the receiver stalls, the output and staging words hold and the
//   controller waits before making a further word; a new sample is refused
//   while a staged word cannot move on.
// ----------------------------------------------------------------------------
module next_greater_element_stack import ngs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ngs_in_if.sink     sample_i,
  ngs_out_if.source  result_o
);

  ngs_cmd_t cmd;
  ngs_sts_t sts;
  ngs_res_t out_word;

  // Controller.
  ngs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  ngs_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .sample_value_i    (sample_i.sample_value),
    .end_of_sequence_i (sample_i.end_of_sequence),
    .out_ready_i       (result_o.ready),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (result_o.valid),
    .out_word_o        (out_word)
  );

  // Result channel payload.
  assign result_o.position      = out_word.position;
  assign result_o.greater_value = out_word.greater_value;
  assign result_o.found         = out_word.found;
  assign result_o.overflow      = out_word.overflow;
  assign result_o.last_of_run   = out_word.last_of_run;

`ifndef SYNTHESIS
  // After a sample is taken, the block is not ready for another in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i.valid && sample_i.ready |=> !sample_i.ready)
    else $error("sample accepted on two consecutive cycles");

  // A new word never overwrites a staged word that cannot drain.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.pop_emit || cmd.ovf_emit || cmd.flush_emit) && sts.stage_full |-> sts.out_free)
    else $error("staged result overwritten while output is stalled");

  // An overflow word is made only when the stack is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ovf_emit |-> sts.stack_full && !cmd.push)
    else $error("overflow reported with room on the stack");
`endif

endmodule

@@ test/tb_next_greater_element_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Next greater element stack: regression testbench
// Streams directed and random sample sequences into the stack, predicts every
// result word with a behavioural monotonic stack of its own and compares each
// received word field by field, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_next_greater_element_stack;
  import ngs_pkg::*;

  localparam int HalfPeriod  = 4;
  localparam int ResetCycles = 6;
  localparam int IdlePercent = 18;
  localparam int HoldAfter   = 80;   // results seen before the long receiver hold-off
  localparam int HoldCycles  = 200;
  localparam int DrainCycles = 80;
  localparam int PhaseAItems = 100;
  localparam int PhaseBItems = 100;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     eos;
  } sample_word_t;

  logic clk;
  logic rst_n;

  ngs_in_if  sample_if ();
  ngs_out_if result_if ();

  next_greater_element_stack i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  // Words waiting to be offered, and result words still to arrive.
  sample_word_t sample_queue[$];
  ngs_res_t     expected_words[$];

  // Shadow monotonic stack.
  logic signed [ValueW-1:0]   nge_vals [StackDepth];
  logic [PositionBits-1:0]    nge_pos  [StackDepth];
  int                         nge_depth;
  logic [PositionBits-1:0]    next_pos;

  logic sample_taken;
  int   items_accepted;
  int   results_seen;
  int   mismatches;
  int   hold_left;
  logic hold_done;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #HalfPeriod clk = ~clk;
  end

  // Fixed limit on the whole run.
  initial begin
    #4_000_000;
    $display("next_greater_element_stack regression: fail");
    $finish;
  end

  // Builds one result word with last_of_run cleared.
  function automatic ngs_res_t make_word(input logic [PositionBits-1:0] pos,
                                         input logic signed [ValueW-1:0] val,
                                         input logic fnd, input logic ovf);
    ngs_res_t w;
    w.position      = pos;
    w.greater_value = val;
    w.found         = fnd;
    w.overflow      = ovf;
    w.last_of_run   = 1'b0;
    return w;
  endfunction

  // Appends one word to the tail of the expected list.
  task automatic append_word(input ngs_res_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  // Works out the result words that one accepted sample causes.
  task automatic resolve_sample(input logic signed [ValueW-1:0] value, input logic eos);
    ngs_res_t w;
    int       first;
    first = expected_words.size();
    // Pop every entry strictly smaller than the new sample.
    while (nge_depth > 0 && nge_vals[nge_depth-1] < value) begin
      nge_depth--;
      append_word(make_word(nge_pos[nge_depth], value, 1'b1, 1'b0));
    end
    // Push, or report the sample untracked when the stack is full.
    if (nge_depth < StackDepth) begin
      nge_vals[nge_depth] = value;
      nge_pos[nge_depth]  = next_pos;
      nge_depth++;
    end else begin
      append_word(make_word(next_pos, '0, 1'b0, 1'b1));
    end
    // The end of a sequence flushes the rest with no greater element.
    if (eos) begin
      while (nge_depth > 0) begin
        nge_depth--;
        append_word(make_word(nge_pos[nge_depth], '0, 1'b0, 1'b0));
      end
      next_pos = '0;
    end else begin
      next_pos = next_pos + PositionBits'(1);
    end
    if (expected_words.size() > first) begin
      w = expected_words.pop_back();
      w.last_of_run = 1'b1;
      append_word(w);
    end
  endtask

  task automatic check_field(input string name, input logic [ValueW-1:0] want_v,
                             input logic [ValueW-1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // Sample handshakes feed the predictor; result handshakes are checked.
  always @(posedge clk) begin : watch_channels
    ngs_res_t got;
    ngs_res_t want;
    if (!rst_n) begin
      sample_taken <= 1'b0;
    end else begin
      sample_taken <= sample_if.valid && sample_if.ready;
      if (result_if.valid && result_if.ready) begin
        got.position      = result_if.position;
        got.greater_value = result_if.greater_value;
        got.found         = result_if.found;
        got.overflow      = result_if.overflow;
        got.last_of_run   = result_if.last_of_run;
        results_seen <= results_seen + 1;
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, actual %0h", $time, got);
        end else begin
          want = expected_words.pop_front();
          check_field("position", ValueW'(want.position), ValueW'(got.position));
          check_field("greater_value", want.greater_value, got.greater_value);
          check_field("found", ValueW'(want.found), ValueW'(got.found));
          check_field("overflow", ValueW'(want.overflow), ValueW'(got.overflow));
          check_field("last_of_run", ValueW'(want.last_of_run), ValueW'(got.last_of_run));
        end
      end
      if (sample_if.valid && sample_if.ready) begin
        resolve_sample(sample_if.sample_value, sample_if.end_of_sequence);
        items_accepted <= items_accepted + 1;
      end
    end
  end

  // Sample driver: holds a word until it is taken, idles at random.
  always @(negedge clk) begin : drive_samples
    logic calm;
    logic offer;
    if (rst_n) begin
      if (sample_taken) begin
        void'(sample_queue.pop_front());
      end
      if (!sample_if.valid || sample_taken) begin
        calm  = items_accepted >= 170 && items_accepted < 230;
        offer = sample_queue.size() > 0 &&
                (calm || $urandom_range(99) >= IdlePercent);
        if (offer) begin
          sample_if.valid           <= 1'b1;
          sample_if.sample_value    <= sample_queue[0].value;
          sample_if.end_of_sequence <= sample_queue[0].eos;
        end else begin
          sample_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, one long hold-off, and a calm stretch.
  always @(negedge clk) begin : drive_ready
    if (hold_left > 0) begin
      result_if.ready <= 1'b0;
      hold_left       <= hold_left - 1;
    end else if (!hold_done && results_seen >= HoldAfter) begin
      result_if.ready <= 1'b0;
      hold_left       <= HoldCycles;
      hold_done       <= 1'b1;
    end else begin
      result_if.ready <= (results_seen >= 180 && results_seen < 240) ||
                         $urandom_range(99) >= IdlePercent;
    end
  end

  task automatic queue_sample(input logic signed [ValueW-1:0] value, input logic eos);
    sample_word_t s;
    s.value = value;
    s.eos   = eos;
    sample_queue.insert(sample_queue.size(), s);
  endtask

  // Waits until every queued sample is taken and every result has arrived.
  task automatic await_drain();
    while (sample_queue.size() != 0 || sample_if.valid || expected_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic signed [ValueW-1:0] step_down(input logic signed [ValueW-1:0] v);
    longint n;
    n = longint'(v) - longint'($urandom_range(3));
    if (n < -64'sd2147483648) n = -64'sd2147483648;
    return n[ValueW-1:0];
  endfunction

  function automatic logic signed [ValueW-1:0] step_up(input logic signed [ValueW-1:0] v);
    longint n;
    n = longint'(v) + longint'($urandom_range(3));
    if (n > 64'sd2147483647) n = 64'sd2147483647;
    return n[ValueW-1:0];
  endfunction

  // Non-increasing run long enough to fill the stack, ended by end of sequence.
  task automatic queue_deep_run(inout int count);
    logic signed [ValueW-1:0] v;
    int len;
    len = $urandom_range(StackDepth + 1, StackDepth + 6);
    v   = $urandom;
    for (int i = 0; i < len; i++) begin
      queue_sample(v, i == len - 1);
      v = step_down(v);
    end
    count += len;
  endtask

  // Random sequences, mostly well formed, until the item count is reached.
  task automatic queue_random(input int target);
    logic signed [ValueW-1:0] v;
    int count;
    int kind;
    int len;
    count = 0;
    while (count < target) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        len = $urandom_range(1, 12);
        v   = $urandom;
        for (int i = 0; i < len; i++) begin
          if (kind < 40) v = $urandom;
          else if (kind < 60) v = $signed($urandom_range(6)) - 3;
          else if (kind < 68) v = step_up(v);
          else v = step_down(v);
          queue_sample(v, i == len - 1);
        end
        count += len;
      end else if (kind < 83) begin
        queue_deep_run(count);
      end else begin
        // Noise: a lone word with a random end marker.
        queue_sample($urandom, 1'($urandom_range(1)));
        count++;
      end
    end
  endtask

  initial begin : stimulus
    int count;
    rst_n                     = 1'b0;
    sample_if.valid           = 1'b0;
    sample_if.sample_value    = '0;
    sample_if.end_of_sequence = 1'b0;
    result_if.ready           = 1'b0;
    sample_taken              = 1'b0;
    items_accepted            = 0;
    results_seen              = 0;
    mismatches                = 0;
    hold_left                 = 0;
    hold_done                 = 1'b0;
    nge_depth                 = 0;
    next_pos                  = '0;
    repeat (ResetCycles) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, equal values, flushes and single-word sequences.
    queue_sample(32'sh8000_0000, 1'b0);
    queue_sample(32'sh7fff_ffff, 1'b0);
    queue_sample(32'sd5, 1'b0);
    queue_sample(32'sd5, 1'b0);
    queue_sample(32'sd6, 1'b0);
    queue_sample(32'sd0, 1'b0);
    queue_sample(-32'sd1, 1'b0);
    queue_sample(32'sh7fff_ffff, 1'b1);
    queue_sample(32'sd0, 1'b1);
    queue_sample(32'sh8000_0000, 1'b1);
    queue_sample(-32'sd1, 1'b0);
    queue_sample(-32'sd1, 1'b0);
    queue_sample(-32'sd1, 1'b1);
    queue_sample(32'sd3, 1'b0);
    queue_sample(32'sd2, 1'b0);
    queue_sample(32'sd1, 1'b0);
    queue_sample(32'sd4, 1'b1);
    queue_sample(32'sh8000_0000, 1'b0);
    queue_sample(32'sh8000_0001, 1'b0);
    queue_sample(32'sh7fff_ffff, 1'b0);
    queue_sample(32'sh7fff_ffff, 1'b1);
    // The sender pauses here until every expected word has come.
    await_drain();

    // Random part, opened by a run that overflows the stack.
    count = 0;
    queue_deep_run(count);
    queue_random(PhaseAItems - count);
    await_drain();
    queue_random(PhaseBItems);
    queue_sample($urandom, 1'b1);
    await_drain();

    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("next_greater_element_stack regression: pass");
    end else begin
      $display("next_greater_element_stack regression: fail");
    end
    $finish;
  end

endmodule
